// ----- hdl/bpc_pkg.sv -----
// Shared types and constants for the button press classifier.
package bpc_pkg;

  localparam int BUTTONS = 3;
  localparam int BtnW    = 2;
  localparam int CntW    = 16;
  localparam int CfgW    = 16;
  localparam int CfgIdxW = 1;

  localparam logic [CntW-1:0] DebounceReset = 16'd100;
  localparam logic [CntW-1:0] LongReset     = 16'd3000;

  // result queue between front and back
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_PRESS_DEB = 3'd1,
    PH_LONG_WAIT = 3'd2,
    PH_HELD      = 3'd3,
    PH_QUIET     = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    ACT_SHORT      = 2'd0,
    ACT_LONG       = 2'd1,
    ACT_HOLD_SHORT = 2'd2
  } act_e;

  typedef enum logic {
    CMD_EDGE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE = 1'b0,
    CFG_LONG     = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic            cmd;
    logic [BtnW-1:0] button;
    logic            pressed;
  } in_item_t;

  typedef struct packed {
    logic [BtnW-1:0] which_button;
    logic [1:0]      action;
    logic            last;
  } out_item_t;

  // All results of one item: one slot per button, in button order.
  typedef struct packed {
    logic [BUTTONS-1:0] hit;
    act_e [BUTTONS-1:0] act;
  } bundle_t;

endpackage

// ----- hdl/bpc_front.sv -----
// Front end: per-button phase machines, timers and config registers.
module bpc_front
  import bpc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_data_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               q_full_i,
  output logic               push_o,
  output bundle_t            push_data_o
);

  phase_e            phase_q [BUTTONS];
  phase_e            phase_d [BUTTONS];
  logic [CntW-1:0]   cnt_q   [BUTTONS];
  logic [CntW-1:0]   cnt_d   [BUTTONS];
  logic [BUTTONS-1:0] level_q, level_d;
  logic [BUTTONS-1:0] run_q, run_d;
  logic [CntW-1:0]   deb_q, long_q;
  logic              in_fire;
  bundle_t           bundle;

  assign in_ready_o = !q_full_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q  <= DebounceReset;
      long_q <= LongReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEBOUNCE: deb_q  <= cfg_data_i;
        CFG_LONG:     long_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    level_d = level_q;
    run_d   = run_q;
    bundle  = '0;
    if (in_fire) begin
      if (in_data_i.cmd == CMD_TICK) begin
        for (int b = 0; b < BUTTONS; b++) begin
          if (run_q[b]) begin
            if (cnt_q[b] > CntW'(1)) begin
              cnt_d[b] = cnt_q[b] - CntW'(1);
            end else begin
              cnt_d[b] = '0;
              run_d[b] = 1'b0;
              case (phase_q[b])
                PH_PRESS_DEB: begin
                  bundle.hit[b] = 1'b1;
                  run_d[b]      = 1'b1;
                  if (level_q[b]) begin
                    cnt_d[b]      = long_q;
                    phase_d[b]    = PH_LONG_WAIT;
                    bundle.act[b] = ACT_HOLD_SHORT;
                  end else begin
                    cnt_d[b]      = deb_q;
                    phase_d[b]    = PH_QUIET;
                    bundle.act[b] = ACT_SHORT;
                  end
                end
                PH_LONG_WAIT: begin
                  bundle.hit[b] = 1'b1;
                  if (level_q[b]) begin
                    phase_d[b]    = PH_HELD;
                    bundle.act[b] = ACT_LONG;
                  end else begin
                    run_d[b]      = 1'b1;
                    cnt_d[b]      = deb_q;
                    phase_d[b]    = PH_QUIET;
                    bundle.act[b] = ACT_SHORT;
                  end
                end
                PH_QUIET: phase_d[b] = PH_IDLE;
                default: ;
              endcase
            end
          end
        end
      end else begin
        // edges for indexes past the last button match no slot
        for (int b = 0; b < BUTTONS; b++) begin
          if (in_data_i.button == BtnW'(b)) begin
            level_d[b] = in_data_i.pressed;
            case (phase_q[b])
              PH_PRESS_DEB, PH_QUIET: ;
              PH_LONG_WAIT: begin
                if (!in_data_i.pressed) begin
                  cnt_d[b]      = deb_q;
                  run_d[b]      = 1'b1;
                  phase_d[b]    = PH_QUIET;
                  bundle.hit[b] = 1'b1;
                  bundle.act[b] = ACT_SHORT;
                end
              end
              PH_HELD: begin
                if (!in_data_i.pressed) begin
                  cnt_d[b]   = deb_q;
                  run_d[b]   = 1'b1;
                  phase_d[b] = PH_QUIET;
                end
              end
              default: begin
                phase_d[b] = PH_IDLE;
                if (in_data_i.pressed) begin
                  cnt_d[b]   = deb_q;
                  run_d[b]   = 1'b1;
                  phase_d[b] = PH_PRESS_DEB;
                end
              end
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < BUTTONS; b++) begin
        phase_q[b] <= PH_IDLE;
        cnt_q[b]   <= '0;
      end
      level_q <= '0;
      run_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      level_q <= level_d;
      run_q   <= run_d;
    end
  end

  assign push_o      = in_fire && (|bundle.hit);
  assign push_data_o = bundle;

`ifndef SYNTHESIS
  a_edge_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_data_i.cmd == CMD_EDGE) |-> $countones(bundle.hit) <= 1)
    else $error("edge beat produced more than one result");
  a_tick_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_data_i.cmd == CMD_TICK) && (run_q == '0) |-> !push_o)
    else $error("tick with no running timer produced a result");
`endif

endmodule

// ----- hdl/bpc_queue.sv -----
// Small FIFO of result bundles between front and back.
module bpc_queue
  import bpc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t push_data_i,
  input  logic    pop_i,
  output bundle_t pop_data_o,
  output logic    full_o,
  output logic    empty_o
);

  bundle_t          mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o     = (cnt_q == QCntW'(QDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // depth is a power of two, so pointers wrap on their own
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + QCntW'(1);
        2'b01:   cnt_q <= cnt_q - QCntW'(1);
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");
`endif

endmodule

// ----- hdl/bpc_back.sv -----
// Back end: unpacks one bundle into result beats, lowest button first.
module bpc_back
  import bpc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_empty_i,
  input  bundle_t   q_data_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic [BUTTONS-1:0] pend_q, pend_d;
  act_e [BUTTONS-1:0] act_q;
  logic [BUTTONS-1:0] first_oh, rest;
  logic [BtnW-1:0]    first_idx;
  logic               out_fire;

  always_comb begin
    first_oh  = '0;
    first_idx = '0;
    for (int b = BUTTONS - 1; b >= 0; b--) begin
      if (pend_q[b]) begin
        first_oh  = '0;
        first_oh[b] = 1'b1;
        first_idx = BtnW'(b);
      end
    end
  end

  assign rest        = pend_q & ~first_oh;
  assign out_valid_o = |pend_q;
  assign out_fire    = out_valid_o && out_ready_i;

  assign out_data_o.which_button = first_idx;
  assign out_data_o.action       = act_q[first_idx];
  assign out_data_o.last         = (rest == '0);

  always_comb begin
    pend_d = out_fire ? rest : pend_q;
    pop_o  = (pend_d == '0) && !q_empty_i;
    if (pop_o) pend_d = q_data_i.hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) act_q <= q_data_i.act;
  end

`ifndef SYNTHESIS
  a_more_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !out_data_o.last |=> out_valid_o)
    else $error("bundle dropped before its last beat");
`endif

endmodule

// ----- hdl/button_press_classifier.sv -----
// Top level of the three-button short/long press classifier.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------
//  in      | in        | in_valid_i/in_ready_o | in_data_i  (cmd, button, pressed)
//  out     | out       | out_valid_o/out_ready_i| out_data_o (which_button, action, last)
//  cfg     | in        | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// The front takes one input beat per cycle while in_ready_o is high and
// updates the affected button state in that cycle. A beat that yields results pushes
// one bundle into a two-entry queue; the back drains a bundle at one result
// beat per cycle while out_ready_i is high. in_ready_o drops only while the
// queue is full. Reset clears all phases, levels and timers and loads the
// default debounce (100) and long-press (3000) periods.
module button_press_classifier
  import bpc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  logic    push, pop, q_full, q_empty;
  bundle_t push_data, pop_data;

  // front: classification and timers
  bpc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // decouples the front from output back-pressure
  bpc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  // back: one result beat per cycle while out_ready_i is high, last flag on the final one
  bpc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the three-button short/long press classifier.
module testbench;
  import bpc_pkg::*;

  localparam int StallLimit = 2000;  // cycles with no beat on any port
  localparam int SettleCycles = 8;   // drain allowance before a register write

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready_o;
  in_item_t            in_data = '0;
  logic                out_valid_o;
  logic                out_ready = 1'b0;
  out_item_t           out_data_o;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgW-1:0]     cfg_data = '0;

  button_press_classifier dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Shadow of the classifier: periods and per-button state.
  logic [CfgW-1:0] deb_ticks;
  logic [CfgW-1:0] long_ticks;
  phase_e          ph    [BUTTONS];
  logic            lvl   [BUTTONS];
  logic [CntW-1:0] cnt   [BUTTONS];
  logic            run   [BUTTONS];

  out_item_t pending_results[$];
  int        mismatch_cnt = 0;
  logic      sent_level [BUTTONS];  // last level driven per button
  bit        in_calm = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic void arm_timer(int b, logic [CntW-1:0] n);
    cnt[b] = n;
    run[b] = 1'b1;
  endfunction

  // Countdown of button b ran out: returns the action or -1.
  function automatic int expire_button(int b);
    case (ph[b])
      PH_PRESS_DEB: begin
        if (lvl[b]) begin
          arm_timer(b, long_ticks);
          ph[b] = PH_LONG_WAIT;
          return ACT_HOLD_SHORT;
        end
        arm_timer(b, deb_ticks);
        ph[b] = PH_QUIET;
        return ACT_SHORT;
      end
      PH_LONG_WAIT: begin
        if (lvl[b]) begin
          ph[b] = PH_HELD;
          return ACT_LONG;
        end
        arm_timer(b, deb_ticks);
        ph[b] = PH_QUIET;
        return ACT_SHORT;
      end
      PH_QUIET: begin
        ph[b] = PH_IDLE;
        return -1;
      end
      default: return -1;  // stray expiry
    endcase
  endfunction

  // Advances the shadow state by one accepted beat and queues its results.
  function automatic void classify_item(in_item_t it);
    out_item_t hits [BUTTONS];
    int        n;
    int        act;
    int        b;
    n = 0;
    if (it.cmd == CMD_TICK) begin
      for (b = 0; b < BUTTONS; b++) begin
        if (!run[b]) continue;
        if (cnt[b] > 1) begin
          cnt[b] = cnt[b] - 1'b1;
          continue;
        end
        cnt[b] = '0;
        run[b] = 1'b0;
        act = expire_button(b);
        if (act >= 0) begin
          hits[n].which_button = BtnW'(b);
          hits[n].action       = act[1:0];
          hits[n].last         = 1'b0;
          n++;
        end
      end
      if (n > 0) hits[n-1].last = 1'b1;
      for (b = 0; b < n; b++) pending_results.push_back(hits[b]);
    end else begin
      if (it.button >= BUTTONS) return;  // no such button
      b = it.button;
      lvl[b] = it.pressed;
      case (ph[b])
        PH_PRESS_DEB, PH_QUIET: ;  // level stored only
        PH_LONG_WAIT: begin
          if (!lvl[b]) begin
            arm_timer(b, deb_ticks);
            ph[b] = PH_QUIET;
            hits[0].which_button = BtnW'(b);
            hits[0].action       = ACT_SHORT;
            hits[0].last         = 1'b1;
            pending_results.push_back(hits[0]);
          end
        end
        PH_HELD: begin
          if (!lvl[b]) begin
            arm_timer(b, deb_ticks);
            ph[b] = PH_QUIET;
          end
        end
        default: begin
          ph[b] = PH_IDLE;
          if (lvl[b]) begin
            arm_timer(b, deb_ticks);
            ph[b] = PH_PRESS_DEB;
          end
        end
      endcase
    end
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: predicts on every input beat, checks every output beat. One
  // process for both so the order of prediction and check is fixed.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (in_valid && in_ready_o) classify_item(in_data);
      if (out_valid_o && out_ready) begin
        if (pending_results.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result: button %0d action %0d last %0b",
                     out_data_o.which_button, out_data_o.action, out_data_o.last);
        end else begin
          want = pending_results.pop_front();
          if (out_data_o.which_button !== want.which_button ||
              out_data_o.action !== want.action ||
              out_data_o.last !== want.last) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("bad result: want button %0d action %0d last %0b, got %0d %0d %0b",
                       want.which_button, want.action, want.last,
                       out_data_o.which_button, out_data_o.action, out_data_o.last);
          end
        end
      end
    end
  end

  // Watchdog: ends the run when no port moves for too long.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || cfg_we || !rst_ni) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Mostly short gaps, a few long ones; none at all in a calm stretch.
  function automatic int idle_len(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver back-pressure.
  initial begin
    int stall;
    bit calm;
    stall = 0;
    calm  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 49) == 0) calm = !calm;
        stall = idle_len(calm);
      end
    end
  end

  // Sends one beat. Valid is left high after acceptance so back-to-back
  // beats never drop it; a gap lowers it at the next falling edge.
  task automatic send_beat(in_item_t it);
    int gap;
    if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
    gap = idle_len(in_calm);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    if (it.cmd == CMD_EDGE && it.button < BUTTONS) sent_level[it.button] = it.pressed;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic in_item_t tick_item();
    in_item_t it;
    it.cmd     = CMD_TICK;
    it.button  = BtnW'($urandom_range(0, 3));  // ignored on a tick
    it.pressed = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic in_item_t edge_item(int b, bit p);
    in_item_t it;
    it.cmd     = CMD_EDGE;
    it.button  = BtnW'(b);
    it.pressed = p;
    return it;
  endfunction

  task automatic send_ticks(int n);
    repeat (n) send_beat(tick_item());
  endtask

  // Lowers valid and waits until every predicted result has come out.
  task automatic settle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DEBOUNCE: deb_ticks = val;
      CFG_LONG:     long_ticks = val;
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset periods: two held buttons fire together on the 100th tick.
  task automatic test_reset_periods();
    send_beat(edge_item(0, 1'b1));
    send_beat(edge_item(1, 1'b1));
    send_ticks(100);
    send_beat(edge_item(0, 1'b0));
    send_beat(edge_item(1, 1'b0));
    send_ticks(100);
  endtask

  task automatic test_directed();
    settle();
    write_reg(CFG_DEBOUNCE, 16'd1);
    write_reg(CFG_LONG, 16'd2);
    // hold through to long press, repeat press while held, release
    send_beat(edge_item(0, 1'b1));
    send_beat(tick_item());
    send_ticks(2);
    send_beat(edge_item(0, 1'b1));
    send_beat(edge_item(0, 0));
    send_beat(tick_item());
    // released inside debounce, then a press swallowed by the quiet wait
    send_beat(edge_item(1, 1'b1));
    send_beat(edge_item(1, 0));
    send_beat(tick_item());
    send_beat(edge_item(1, 1'b1));
    send_beat(tick_item());
    send_beat(edge_item(1, 0));
    // no such button
    send_beat(edge_item(3, 1'b1));
    // all three fire on one tick; release during long wait
    send_beat(edge_item(0, 1'b1));
    send_beat(edge_item(1, 1'b1));
    send_beat(edge_item(2, 1'b1));
    send_beat(tick_item());
    send_beat(edge_item(2, 0));
    send_ticks(2);
    send_beat(edge_item(0, 0));
    send_beat(edge_item(1, 0));
    send_beat(tick_item());
  endtask

  // Zero periods expire on the very next tick.
  task automatic test_zero_periods();
    settle();
    write_reg(CFG_DEBOUNCE, 16'd0);
    write_reg(CFG_LONG, 16'd0);
    send_beat(edge_item(2, 1'b1));
    send_ticks(2);
    send_beat(edge_item(2, 0));
    send_beat(tick_item());
  endtask

  // Mostly level toggles and ticks, a little noise; several period settings.
  task automatic test_random_traffic();
    in_item_t it;
    int       tick_pct;
    int       counted;
    int       b;
    for (int phase_no = 0; phase_no < 8; phase_no++) begin
      settle();
      write_reg(CFG_DEBOUNCE, ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 4)));
      write_reg(CFG_LONG, ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 6)));
      tick_pct = $urandom_range(30, 65);
      counted  = 0;
      while (counted < 32) begin
        if ($urandom_range(0, 99) < tick_pct) begin
          it = tick_item();
          counted++;
        end else if ($urandom_range(0, 99) < 5) begin
          it = edge_item(3, 1'($urandom_range(0, 1)));  // ignored by the block
        end else begin
          b = $urandom_range(0, BUTTONS - 1);
          it = edge_item(b, ($urandom_range(0, 99) < 85) ? !sent_level[b] : sent_level[b]);
          counted++;
        end
        send_beat(it);
      end
    end
  endtask

  // Full-scale periods: nothing new may expire within a handful of ticks.
  task automatic test_max_periods();
    settle();
    write_reg(CFG_DEBOUNCE, 16'hFFFF);
    write_reg(CFG_LONG, 16'hFFFF);
    send_beat(edge_item(0, !sent_level[0]));
    send_beat(edge_item(1, !sent_level[1]));
    send_ticks(6);
    send_beat(edge_item(2, !sent_level[2]));
    send_ticks(6);
  endtask

  initial begin
    deb_ticks  = DebounceReset;
    long_ticks = LongReset;
    for (int b = 0; b < BUTTONS; b++) begin
      ph[b]         = PH_IDLE;
      lvl[b]        = 1'b0;
      cnt[b]        = '0;
      run[b]        = 1'b0;
      sent_level[b] = 1'b0;
    end
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_periods();
    test_directed();
    test_zero_periods();
    test_random_traffic();
    test_max_periods();

    settle();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/bpc_pkg.sv
hdl/bpc_front.sv
hdl/bpc_queue.sv
hdl/bpc_back.sv
hdl/button_press_classifier.sv
tb/testbench.sv
